// File: hdl/dtbcd_pkg.sv
// Shared types, limits and conversion helpers for the calendar-time to BCD packer.
`default_nettype none

package dtbcd_pkg;

   // Saturation limits of the binary fields
   localparam logic [7:0]  SEC_MAX   = 8'd59;
   localparam logic [7:0]  MIN_MAX   = 8'd59;
   localparam logic [7:0]  HOUR_MAX  = 8'd23;
   localparam logic [7:0]  DAY_MAX   = 8'd31;
   localparam logic [7:0]  MONTH_MAX = 8'd12;
   localparam logic [15:0] YEAR_MAX  = 16'd2099;
   localparam logic [15:0] YEAR_BASE = 16'd2000;

   // Two-digit year at the top of the range
   localparam logic [6:0]  YY_MAX    = 7'd99;

   // Month codes that count as part of the previous year for the weekday
   localparam logic [3:0]  MONTH_JAN = 4'd1;
   localparam logic [3:0]  MONTH_FEB = 4'd2;

   // One packed result image
   typedef struct packed {
      logic [6:0] seconds_bcd;
      logic [6:0] minutes_bcd;
      logic [5:0] hours_bcd;
      logic [5:0] day_bcd;
      logic [2:0] weekday;
      logic [4:0] month_bcd;
      logic [7:0] year_bcd;
   } rsp_type;

   // Binary 0..99 to packed BCD; tens by reciprocal multiply (exact here)
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [6:0]  ones;
      prod     = {8'd0, v} * 15'd205;
      tens     = prod[14:11];
      tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
      ones     = v - tens_x10;
      return {tens, ones[3:0]};
   endfunction

   // ((13*m - 1) / 5) mod 7 with m the March-based month index
   function automatic logic [2:0] month_offset(input logic [3:0] mon);
      logic [2:0] off;
      case (mon)
         4'd1:    off = 3'd0;
         4'd2:    off = 3'd3;
         4'd3:    off = 3'd2;
         4'd4:    off = 3'd5;
         4'd5:    off = 3'd0;
         4'd6:    off = 3'd3;
         4'd7:    off = 3'd5;
         4'd8:    off = 3'd1;
         4'd9:    off = 3'd4;
         4'd10:   off = 3'd6;
         4'd11:   off = 3'd2;
         4'd12:   off = 3'd4;
         default: off = 3'd4; // month zero behaves like December
      endcase
      return off;
   endfunction

   // Remainder by 7 of an 8-bit value: octal digits fold since 8 = 1 mod 7
   function automatic logic [2:0] mod7(input logic [7:0] x);
      logic [4:0] s;
      logic [3:0] t;
      s = {3'b000, x[7:6]} + {2'b00, x[5:3]} + {2'b00, x[2:0]};
      t = {2'b00, s[4:3]} + {1'b0, s[2:0]};
      return (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
   endfunction

endpackage

`default_nettype wire

// File: hdl/datetime_to_bcd_rtc_packer.sv
// Top level: binary calendar time in, packed BCD clock register image out.
`default_nettype none

// A new time value is taken in every cycle in which start is high and busy
// is low; busy is high during reset and the cycle after it. Each result
// passes through one input register and one result register, with the
// saturation, BCD packing and weekday logic between them, and is held on
// the rsp_ ports for exactly one cycle, flagged by rsp_valid. The receiver
// cannot stall, so it must take every result in the cycle it is shown.
// Fields are clamped to second 59, minute 59, hour 23, day 31, month 12 and
// year 2000..2099; the weekday runs 0 (Sunday) to 6 (Saturday).

module datetime_to_bcd_rtc_packer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [7:0]  req_second,
   input  wire logic [7:0]  req_minute,
   input  wire logic [7:0]  req_hour,
   input  wire logic [7:0]  req_day_of_month,
   input  wire logic [7:0]  req_month,
   input  wire logic [15:0] req_year,
   output logic             rsp_valid,
   output logic [6:0]       rsp_seconds_bcd,
   output logic [6:0]       rsp_minutes_bcd,
   output logic [5:0]       rsp_hours_bcd,
   output logic [5:0]       rsp_day_bcd,
   output logic [2:0]       rsp_weekday,
   output logic [4:0]       rsp_month_bcd,
   output logic [7:0]       rsp_year_bcd
);

   logic                 busy_ff;
   logic                 req_transfer;
   logic                 in_valid_ff;
   logic [7:0]           second_ff;
   logic [7:0]           minute_ff;
   logic [7:0]           hour_ff;
   logic [7:0]           day_ff;
   logic [7:0]           month_ff;
   logic [15:0]          year_ff;
   dtbcd_pkg::rsp_type   result_in;
   dtbcd_pkg::rsp_type   result_ff;
   logic                 rsp_valid_ff;

   assign req_transfer = start && !busy_ff;

   // Control: busy only right out of reset, valid follows the two stages
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         in_valid_ff  <= req_transfer;
         rsp_valid_ff <= in_valid_ff;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         second_ff <= req_second;
         minute_ff <= req_minute;
         hour_ff   <= req_hour;
         day_ff    <= req_day_of_month;
         month_ff  <= req_month;
         year_ff   <= req_year;
      end
   end

   dtbcd_core u_core (
      .second       (second_ff),
      .minute       (minute_ff),
      .hour         (hour_ff),
      .day_of_month (day_ff),
      .month        (month_ff),
      .year         (year_ff),
      .result       (result_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign busy            = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_seconds_bcd = result_ff.seconds_bcd;
   assign rsp_minutes_bcd = result_ff.minutes_bcd;
   assign rsp_hours_bcd   = result_ff.hours_bcd;
   assign rsp_day_bcd     = result_ff.day_bcd;
   assign rsp_weekday     = result_ff.weekday;
   assign rsp_month_bcd   = result_ff.month_bcd;
   assign rsp_year_bcd    = result_ff.year_bcd;

`ifndef ASSERT_OFF
   // Every accepted time value yields a result strobe on rsp_valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("result strobe missing two cycles after transfer");

   // No result without a matching earlier transfer
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result strobe without a matching transfer");

   // Weekday stays in range and seconds are valid BCD
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weekday <= 3'd6) && (rsp_seconds_bcd[3:0] <= 4'd9)
                    && (rsp_seconds_bcd[6:4] <= 3'd5))
      else $error("weekday or seconds BCD out of range");
`endif

endmodule

`default_nettype wire

// File: hdl/dtbcd_core.sv
// Combinational saturation, BCD packing and weekday computation for one time value.
`default_nettype none

module dtbcd_core (
   input  wire logic [7:0]         second,
   input  wire logic [7:0]         minute,
   input  wire logic [7:0]         hour,
   input  wire logic [7:0]         day_of_month,
   input  wire logic [7:0]         month,
   input  wire logic [15:0]        year,
   output dtbcd_pkg::rsp_type      result
);

   logic [5:0] sec_sat;
   logic [5:0] min_sat;
   logic [4:0] hour_sat;
   logic [4:0] day_sat;
   logic [3:0] mon_sat;
   logic [6:0] yy_sat;
   logic [15:0] yy_full;
   logic       prev_year;
   logic       prev_century;
   logic [6:0] d_term;
   logic [7:0] n_sum;
   logic [7:0] sec_bcd;
   logic [7:0] min_bcd;
   logic [7:0] hour_bcd;
   logic [7:0] day_bcd;
   logic [7:0] mon_bcd;
   logic [7:0] yy_bcd;

   // Clamp each field to its legal top value; the year is also raised to its base
   always_comb begin
      sec_sat  = (second > dtbcd_pkg::SEC_MAX) ? dtbcd_pkg::SEC_MAX[5:0] : second[5:0];
      min_sat  = (minute > dtbcd_pkg::MIN_MAX) ? dtbcd_pkg::MIN_MAX[5:0] : minute[5:0];
      hour_sat = (hour > dtbcd_pkg::HOUR_MAX) ? dtbcd_pkg::HOUR_MAX[4:0] : hour[4:0];
      day_sat  = (day_of_month > dtbcd_pkg::DAY_MAX) ? dtbcd_pkg::DAY_MAX[4:0]
                                                     : day_of_month[4:0];
      mon_sat  = (month > dtbcd_pkg::MONTH_MAX) ? dtbcd_pkg::MONTH_MAX[3:0] : month[3:0];
      yy_full  = year - dtbcd_pkg::YEAR_BASE;
      if (year > dtbcd_pkg::YEAR_MAX) begin
         yy_sat = dtbcd_pkg::YY_MAX;
      end else if (year < dtbcd_pkg::YEAR_BASE) begin
         yy_sat = 7'd0;
      end else begin
         yy_sat = yy_full[6:0];
      end
   end

   // Weekday congruence; January and February count in the previous year,
   // which for year 2000 drops into the 1900s century term
   always_comb begin
      prev_year    = (mon_sat == dtbcd_pkg::MONTH_JAN) || (mon_sat == dtbcd_pkg::MONTH_FEB);
      prev_century = prev_year && (yy_sat == 7'd0);
      if (prev_century) begin
         d_term = dtbcd_pkg::YY_MAX;
      end else begin
         d_term = yy_sat - {6'd0, prev_year};
      end
      // century part c/4 + 5c is 0 mod 7 for c = 20 and 1 mod 7 for c = 19
      n_sum = {5'd0, dtbcd_pkg::month_offset(mon_sat)} + {1'b0, d_term}
            + {3'd0, d_term[6:2]} + {7'd0, prev_century} + {3'd0, day_sat};
   end

   // BCD packing
   always_comb begin
      sec_bcd  = dtbcd_pkg::to_bcd({1'b0, sec_sat});
      min_bcd  = dtbcd_pkg::to_bcd({1'b0, min_sat});
      hour_bcd = dtbcd_pkg::to_bcd({2'b00, hour_sat});
      day_bcd  = dtbcd_pkg::to_bcd({2'b00, day_sat});
      mon_bcd  = dtbcd_pkg::to_bcd({3'b000, mon_sat});
      yy_bcd   = dtbcd_pkg::to_bcd(yy_sat);
   end

   assign result.seconds_bcd = sec_bcd[6:0];
   assign result.minutes_bcd = min_bcd[6:0];
   assign result.hours_bcd   = hour_bcd[5:0];
   assign result.day_bcd     = day_bcd[5:0];
   assign result.weekday     = dtbcd_pkg::mod7(n_sum);
   assign result.month_bcd   = mon_bcd[4:0];
   assign result.year_bcd    = yy_bcd;

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for the calendar-time to packed BCD clock register packer.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Holds predicted register images and checks the packer output against them
   class rtc_image_scoreboard;
      dtbcd_pkg::rsp_type expected_images[$];
      int unsigned mismatches;
      int unsigned images_checked;
      int unsigned clamped_times;

      function logic [7:0] pack_bcd(int unsigned v);
         return 8'(((v / 10) << 4) | (v % 10));
      endfunction

      function int unsigned clamp_hi(int unsigned v, int unsigned hi);
         return (v > hi) ? hi : v;
      endfunction

      // Gregorian congruence on a March-based month, Sunday = 0
      function logic [2:0] weekday_of(int unsigned dom, int unsigned mon, int unsigned yr);
         int unsigned mar_mon;
         int unsigned adj_year;
         int unsigned cent;
         int unsigned yy;
         int unsigned total;
         mar_mon  = 1 + (9 + mon) % 12;
         adj_year = yr - ((mar_mon > 10) ? 1 : 0);
         cent     = adj_year / 100;
         yy       = adj_year % 100;
         total    = (13 * mar_mon - 1) / 5 + yy + yy / 4 + cent / 4 + 5 * cent + dom;
         return 3'(total % 7);
      endfunction

      function dtbcd_pkg::rsp_type predict_rtc_image(logic [7:0] sec, logic [7:0] mnt,
                                                     logic [7:0] hr, logic [7:0] dom,
                                                     logic [7:0] mon, logic [15:0] yr);
         dtbcd_pkg::rsp_type img;
         int unsigned s, m, h, d, mo, y;
         s  = clamp_hi(sec, 59);
         m  = clamp_hi(mnt, 59);
         h  = clamp_hi(hr, 23);
         d  = clamp_hi(dom, 31);
         mo = clamp_hi(mon, 12);
         y  = clamp_hi(yr, 2099);
         // years before the base are pulled up so the two-digit year never wraps
         if (y < 2000) y = 2000;
         if (s != sec || m != mnt || h != hr || d != dom || mo != mon || y != yr)
            clamped_times++;
         img.seconds_bcd = 7'(pack_bcd(s));
         img.minutes_bcd = 7'(pack_bcd(m));
         img.hours_bcd   = 6'(pack_bcd(h));
         img.day_bcd     = 6'(pack_bcd(d));
         img.weekday     = weekday_of(d, mo, y);
         img.month_bcd   = 5'(pack_bcd(mo));
         img.year_bcd    = pack_bcd(y - 2000);
         return img;
      endfunction

      function void note_time(logic [7:0] sec, logic [7:0] mnt, logic [7:0] hr,
                              logic [7:0] dom, logic [7:0] mon, logic [15:0] yr);
         expected_images.push_back(predict_rtc_image(sec, mnt, hr, dom, mon, yr));
      endfunction

      function void report_error(string msg);
         mismatches++;
         if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
      endfunction

      function void check_image(dtbcd_pkg::rsp_type got);
         dtbcd_pkg::rsp_type exp;
         if (expected_images.size() == 0) begin
            report_error($sformatf("unexpected result %p", got));
            return;
         end
         exp = expected_images.pop_front();
         images_checked++;
         if (exp.seconds_bcd != got.seconds_bcd || exp.minutes_bcd != got.minutes_bcd ||
             exp.hours_bcd != got.hours_bcd || exp.day_bcd != got.day_bcd ||
             exp.weekday != got.weekday || exp.month_bcd != got.month_bcd ||
             exp.year_bcd != got.year_bcd)
            report_error($sformatf("expected %p, got %p", exp, got));
      endfunction

      function int unsigned pending();
         return expected_images.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [7:0]  req_second = '0;
   logic [7:0]  req_minute = '0;
   logic [7:0]  req_hour = '0;
   logic [7:0]  req_day_of_month = '0;
   logic [7:0]  req_month = '0;
   logic [15:0] req_year = '0;
   logic        rsp_valid;
   logic [6:0]  rsp_seconds_bcd;
   logic [6:0]  rsp_minutes_bcd;
   logic [5:0]  rsp_hours_bcd;
   logic [5:0]  rsp_day_bcd;
   logic [2:0]  rsp_weekday;
   logic [4:0]  rsp_month_bcd;
   logic [7:0]  rsp_year_bcd;

   rtc_image_scoreboard image_board = new();
   int unsigned directed_sent;
   int unsigned random_sent;
   bit          no_idle;

   datetime_to_bcd_rtc_packer u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_second       (req_second),
      .req_minute       (req_minute),
      .req_hour         (req_hour),
      .req_day_of_month (req_day_of_month),
      .req_month        (req_month),
      .req_year         (req_year),
      .rsp_valid        (rsp_valid),
      .rsp_seconds_bcd  (rsp_seconds_bcd),
      .rsp_minutes_bcd  (rsp_minutes_bcd),
      .rsp_hours_bcd    (rsp_hours_bcd),
      .rsp_day_bcd      (rsp_day_bcd),
      .rsp_weekday      (rsp_weekday),
      .rsp_month_bcd    (rsp_month_bcd),
      .rsp_year_bcd     (rsp_year_bcd)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result monitor: every strobed image is checked in its one cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         image_board.check_image('{rsp_seconds_bcd, rsp_minutes_bcd, rsp_hours_bcd,
                                   rsp_day_bcd, rsp_weekday, rsp_month_bcd, rsp_year_bcd});
   end

   // Present one time value and hold it until the transfer happens
   task automatic send_time(logic [7:0] sec, logic [7:0] mnt, logic [7:0] hr,
                            logic [7:0] dom, logic [7:0] mon, logic [15:0] yr);
      start            <= 1'b1;
      req_second       <= sec;
      req_minute       <= mnt;
      req_hour         <= hr;
      req_day_of_month <= dom;
      req_month        <= mon;
      req_year         <= yr;
      do @(posedge clock); while (busy);
      image_board.note_time(sec, mnt, hr, dom, mon, yr);
   endtask

   // Random sender gap; fields carry junk while start is low
   task automatic sender_gap();
      int unsigned pick;
      int unsigned gap;
      pick = $urandom_range(0, 99);
      gap  = no_idle ? 0 : (pick < 60) ? 0 : (pick < 90) ? $urandom_range(1, 3)
                                                         : $urandom_range(8, 30);
      if (gap > 0) begin
         start            <= 1'b0;
         req_second       <= 8'($urandom);
         req_minute       <= 8'($urandom);
         req_hour         <= 8'($urandom);
         req_day_of_month <= 8'($urandom);
         req_month        <= 8'($urandom);
         req_year         <= 16'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Mostly legal values, some near the clamp limit, the rest anywhere in the field
   function automatic logic [15:0] pick_field(int unsigned lo, int unsigned hi,
                                              int unsigned full);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return 16'($urandom_range(lo, hi));
      if (pick < 85) return 16'($urandom_range(hi - 2, hi + 2));
      return 16'($urandom_range(0, full));
   endfunction

   task automatic send_directed(logic [7:0] sec, logic [7:0] mnt, logic [7:0] hr,
                                logic [7:0] dom, logic [7:0] mon, logic [15:0] yr);
      send_time(sec, mnt, hr, dom, mon, yr);
      directed_sent++;
      sender_gap();
   endtask

   initial begin
      int unsigned drain;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, clamp limits and calendar corner cases
      no_idle = 1'b0;
      send_directed(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
      send_directed(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
      send_directed(8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 16'd2099);
      send_directed(8'd60, 8'd60, 8'd24, 8'd32, 8'd13, 16'd2100);
      send_directed(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 16'd2000);    // Saturday
      send_directed(8'd30, 8'd15, 8'd12, 8'd1, 8'd1, 16'd1999); // year raised to base
      send_directed(8'd9, 8'd10, 8'd19, 8'd15, 8'd0, 16'd2024); // month zero as December
      send_directed(8'd1, 8'd2, 8'd3, 8'd0, 8'd3, 16'd2024);    // day zero
      send_directed(8'd1, 8'd2, 8'd3, 8'd31, 8'd2, 16'd2023);   // past end of February
      send_directed(8'd45, 8'd30, 8'd6, 8'd29, 8'd2, 16'd2000);
      send_directed(8'd45, 8'd30, 8'd6, 8'd1, 8'd3, 16'd2000);
      send_directed(8'd10, 8'd20, 8'd9, 8'd31, 8'd12, 16'd2099);
      send_directed(8'd19, 8'd29, 8'd20, 8'd30, 8'd11, 16'd2050);
      send_directed(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 16'h5555);
      send_directed(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 16'hAAAA);
      send_directed(8'd58, 8'd1, 8'd22, 8'd1, 8'd1, 16'd2001);
      no_idle = 1'b1;
      for (int i = 1; i <= 6; i++) send_directed(8'(i * 9), 8'(i * 7), 8'(i * 3), 8'(i * 5),
                                                 8'(i * 2), 16'(2010 + i * 11));

      // Random: stretches with or without sender gaps, chosen at random
      for (int i = 0; i < 400; i++) begin
         if (i % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);
         send_time(8'(pick_field(0, 59, 255)), 8'(pick_field(0, 59, 255)),
                   8'(pick_field(0, 23, 255)), 8'(pick_field(1, 31, 255)),
                   8'(pick_field(1, 12, 255)), pick_field(2000, 2099, 65535));
         random_sent++;
         sender_gap();
      end
      start <= 1'b0;

      // Drain outstanding images, then watch for stray strobes
      drain = 0;
      while (image_board.pending() != 0 && drain < 50) begin
         @(posedge clock);
         drain++;
      end
      repeat (5) @(posedge clock);
      if (image_board.pending() != 0)
         image_board.report_error($sformatf("%0d results never arrived",
                                            image_board.pending()));

      $display("Sent %0d time values (%0d directed, %0d random), %0d with clamped fields.",
               directed_sent + random_sent, directed_sent, random_sent,
               image_board.clamped_times);
      $display("Checked %0d register images, %0d errors.", image_board.images_checked,
               image_board.mismatches);
      if (image_board.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("Timeout: simulation ran too long");
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
